@@ rtl/blbct_pkg.sv @@
// shared types and codes for the bucketed lru buffer cache tag controller
package blbct_pkg;

  // default sizes
  localparam int SLOT_COUNT_DEF   = 32;
  localparam int BUCKET_COUNT_DEF = 8;

  // field widths
  localparam int SECTOR_W = 32;
  localparam int DEV_W    = 8;
  localparam int CNT_W    = 8;
  localparam int STAMP_W  = 32;
  // home bucket as carried in the queue, six bits, enough for up to 64 buckets
  localparam int HOME_W   = 6;

  // operation codes
  localparam logic [1:0] FUNC_READ    = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_PIN     = 2'd2;
  localparam logic [1:0] FUNC_UNPIN   = 2'd3;

  // status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_FILL      = 3'd1;
  localparam logic [2:0] ST_NOBUF     = 3'd2;
  localparam logic [2:0] ST_UPDATED   = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  typedef struct packed {
    logic [1:0]          func;
    logic [DEV_W-1:0]    device_id;
    logic [SECTOR_W-1:0] sector_number;
    logic [4:0]          slot_index;
  } in_t;

  typedef struct packed {
    logic [4:0] slot_out;
    logic [2:0] status;
    logic       was_stolen;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    in_t               req;
    logic [HOME_W-1:0] home;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/blbct_front.sv @@
// front end: accepts requests and hashes the sector of a read to its home bucket
module blbct_front #(
  parameter int BUCKET_COUNT = blbct_pkg::BUCKET_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  blbct_pkg::in_t     in_req,
  output logic               busy,
  input  blbct_pkg::q_stat_t q_stat,
  output logic               push,
  output blbct_pkg::job_t    push_job
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  // weight of each sector byte modulo the bucket count
  localparam logic [6:0] W0 = 7'(1 % BUCKET_COUNT);
  localparam logic [6:0] W1 = 7'((1 << 8) % BUCKET_COUNT);
  localparam logic [6:0] W2 = 7'((1 << 16) % BUCKET_COUNT);
  localparam logic [6:0] W3 = 7'((1 << 24) % BUCKET_COUNT);
  // reciprocal of the bucket count, exact for any 16 bit folded value
  localparam int SH = 16 + $clog2(BUCKET_COUNT);
  localparam longint MUL_L = ((longint'(1) << SH) + longint'(BUCKET_COUNT) - 1) /
                             longint'(BUCKET_COUNT);
  localparam logic [23:0] MUL = 24'(MUL_L);
  localparam logic [6:0]  BK  = 7'(BUCKET_COUNT);
  localparam logic [1:0]  STEPS = 2'd2;

  logic                 hold_r;
  blbct_pkg::in_t       req_r;
  logic [1:0]           step_r;
  logic [15:0]          fold_r;
  logic [15:0]          quo_r;
  logic [15:0]          fold_nxt;
  logic [39:0]          prod;
  logic [15:0]          quo_nxt;
  logic [22:0]          qk;
  logic [15:0]          rem_full;
  logic [BW-1:0]        rem;
  logic                 calc_done;

  // fold the sector bytes into 16 bits; the residue holds while the sum fits
  always_comb begin
    fold_nxt = 16'(req_r.sector_number[7:0])   * 16'(W0)
             + 16'(req_r.sector_number[15:8])  * 16'(W1)
             + 16'(req_r.sector_number[23:16]) * 16'(W2)
             + 16'(req_r.sector_number[31:24]) * 16'(W3);
  end

  // quotient by reciprocal multiply, remainder by one constant multiply
  always_comb begin
    prod     = 40'(fold_r) * 40'(MUL);
    quo_nxt  = prod[SH +: 16];
    qk       = 23'(quo_r) * 23'(BK);
    rem_full = fold_r - 16'(qk);
    rem      = BW'(rem_full);
  end

  assign calc_done = (req_r.func != blbct_pkg::FUNC_READ) || (step_r == STEPS);
  assign push      = hold_r && calc_done && !q_stat.full;
  assign busy      = hold_r;

  always_comb begin
    push_job.req  = req_r;
    push_job.home = blbct_pkg::HOME_W'(rem);
  end

  // request holding register and hash steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (start && !hold_r) begin
      hold_r <= 1'b1;
      req_r  <= in_req;
      step_r <= '0;
    end else if (hold_r) begin
      if (!calc_done) begin
        fold_r <= fold_nxt;
        quo_r  <= quo_nxt;
        step_r <= step_r + 2'd1;
      end else if (push) begin
        hold_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/blbct_queue.sv @@
// two entry queue of classified requests between front and back
module blbct_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  blbct_pkg::job_t    push_job,
  input  logic               pop,
  output blbct_pkg::job_t    head_job,
  output blbct_pkg::q_stat_t q_stat
);

  blbct_pkg::job_t ent_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;

  assign head_job     = ent_r[rp_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/blbct_back.sv @@
// back end: tag scan, victim choice, reference counts and result strobe
module blbct_back #(
  parameter int SLOT_COUNT   = blbct_pkg::SLOT_COUNT_DEF,
  parameter int BUCKET_COUNT = blbct_pkg::BUCKET_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  blbct_pkg::q_stat_t q_stat,
  input  blbct_pkg::job_t    head_job,
  output logic               pop,
  output logic               out_valid,
  output blbct_pkg::out_t    out_res
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [CW-1:0] SLOTS  = CW'(SLOT_COUNT);
  localparam logic [BW-1:0] BK_MAX = BW'(BUCKET_COUNT - 1);
  localparam int CN = blbct_pkg::CNT_W;

  typedef struct packed {
    logic [blbct_pkg::DEV_W-1:0]    dev;
    logic [blbct_pkg::SECTOR_W-1:0] sec;
    logic [blbct_pkg::STAMP_W-1:0]  stamp;
    logic [BW-1:0]                  bucket;
    logic                           valid;
  } tag_row_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_CNT_RD, S_CNT_UPD} state_t;

  // tag and count memories, each entry reads as its reset value until written
  tag_row_t        tag_mem [SLOT_COUNT];
  logic [CN-1:0]   cnt_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] tag_touch_r;
  logic [SLOT_COUNT-1:0] cnt_touch_r;

  tag_row_t        tag_rd_r;
  logic [CN-1:0]   cnt_rd_r;
  logic            ttouch_q_r;
  logic            ctouch_q_r;
  logic [BW-1:0]   rb_q_r;

  logic [IW-1:0]   rd_addr;
  tag_row_t        tag_eff;
  logic [CN-1:0]   cnt_eff;

  logic            tag_we;
  logic [IW-1:0]   tag_wa;
  tag_row_t        tag_wd;
  logic            cnt_we;
  logic [IW-1:0]   cnt_wa;
  logic [CN-1:0]   cnt_wd;

  state_t                        state_r;
  blbct_pkg::job_t               job_r;
  logic [blbct_pkg::STAMP_W-1:0] use_clk_r;
  logic [CW-1:0]                 sa_r;
  logic [BW-1:0]                 rb_r;
  logic                          pvld_r;
  logic [IW-1:0]                 pidx_r;
  logic                          pass2_r;
  logic                          hf_r;
  logic [IW-1:0]                 hidx_r;
  tag_row_t                      hrow_r;
  logic [CN-1:0]                 hcnt_r;
  logic                          vf_r;
  logic [IW-1:0]                 vidx_r;
  logic [blbct_pkg::STAMP_W-1:0] vstamp_r;
  logic                          of_r;
  logic [BW-1:0]                 obk_r;
  logic                          out_valid_r;
  blbct_pkg::out_t               out_res_r;

  logic [BW-1:0] home;
  logic [BW-1:0] tgt_bk;
  logic          hit_m;
  logic          vic_m;
  logic          oth_m;
  logic          free_m;
  logic [CN-1:0] cnt_inc;
  logic [CN-1:0] hcnt_inc;
  logic          idx_oob;

  assign home    = BW'(job_r.home);
  assign tgt_bk  = pass2_r ? obk_r : home;
  assign pop     = (state_r == S_IDLE) && !q_stat.empty;
  assign idx_oob = int'(head_job.req.slot_index) >= SLOT_COUNT;

  // read address: scan pointer or addressed slot
  assign rd_addr = (state_r == S_SCAN) ? IW'(sa_r) : IW'(job_r.req.slot_index);

  // memory ports
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    tag_rd_r   <= tag_mem[rd_addr];
    cnt_rd_r   <= cnt_mem[rd_addr];
    ttouch_q_r <= tag_touch_r[rd_addr];
    ctouch_q_r <= cnt_touch_r[rd_addr];
    rb_q_r     <= rb_r;
  end

  // written marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_touch_r <= '0;
      cnt_touch_r <= '0;
    end else begin
      if (tag_we) begin
        tag_touch_r[tag_wa] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_touch_r[cnt_wa] <= 1'b1;
      end
    end
  end

  // entry as seen by the scan and the count update, reset value when never written
  always_comb begin
    if (ttouch_q_r) begin
      tag_eff = tag_rd_r;
    end else begin
      tag_eff.dev    = '1;
      tag_eff.sec    = '1;
      tag_eff.stamp  = '0;
      tag_eff.bucket = rb_q_r;
      tag_eff.valid  = 1'b0;
    end
    cnt_eff = ctouch_q_r ? cnt_rd_r : '0;
  end

  // per entry match terms
  always_comb begin
    free_m = (cnt_eff == '0);
    hit_m  = !pass2_r && (tag_eff.bucket == home) &&
             (tag_eff.dev == job_r.req.device_id) &&
             (tag_eff.sec == job_r.req.sector_number);
    vic_m  = free_m && (tag_eff.bucket == tgt_bk) &&
             (!vf_r || (tag_eff.stamp < vstamp_r));
    oth_m  = !pass2_r && free_m && (tag_eff.bucket != home) &&
             (!of_r || (tag_eff.bucket < obk_r));
    cnt_inc  = (cnt_eff == '1) ? cnt_eff : cnt_eff + CN'(1);
    hcnt_inc = (hcnt_r == '1) ? hcnt_r : hcnt_r + CN'(1);
  end

  // memory write requests
  always_comb begin
    tag_we = 1'b0;
    tag_wa = hidx_r;
    tag_wd = hrow_r;
    cnt_we = 1'b0;
    cnt_wa = hidx_r;
    cnt_wd = hcnt_inc;
    if (state_r == S_DECIDE) begin
      if (hf_r) begin
        tag_we       = 1'b1;
        tag_wd.valid = 1'b1;
        tag_wd.stamp = use_clk_r + 32'd1;
        cnt_we       = 1'b1;
      end else if (vf_r) begin
        tag_we        = 1'b1;
        tag_wa        = vidx_r;
        tag_wd.dev    = job_r.req.device_id;
        tag_wd.sec    = job_r.req.sector_number;
        tag_wd.stamp  = use_clk_r + 32'd1;
        tag_wd.bucket = home;
        tag_wd.valid  = 1'b1;
        cnt_we        = 1'b1;
        cnt_wa        = vidx_r;
        cnt_wd        = CN'(1);
      end
    end else if (state_r == S_CNT_UPD) begin
      cnt_wa = IW'(job_r.req.slot_index);
      if (job_r.req.func == blbct_pkg::FUNC_PIN) begin
        cnt_we = 1'b1;
        cnt_wd = cnt_inc;
      end else if (cnt_eff != '0) begin
        cnt_we = 1'b1;
        cnt_wd = cnt_eff - CN'(1);
      end
    end
  end

  // sequencer, scan trackers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      use_clk_r   <= '0;
      out_valid_r <= 1'b0;
      pvld_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            job_r <= head_job;
            if (head_job.req.func == blbct_pkg::FUNC_READ) begin
              state_r <= S_SCAN;
              pass2_r <= 1'b0;
              sa_r    <= '0;
              rb_r    <= '0;
              pvld_r  <= 1'b0;
              hf_r    <= 1'b0;
              vf_r    <= 1'b0;
              of_r    <= 1'b0;
            end else if (idx_oob) begin
              out_valid_r          <= 1'b1;
              out_res_r.slot_out   <= head_job.req.slot_index;
              out_res_r.status     <= blbct_pkg::ST_UNDERFLOW;
              out_res_r.was_stolen <= 1'b0;
            end else begin
              state_r <= S_CNT_RD;
            end
          end
        end
        S_SCAN: begin
          // issue side
          if (sa_r != SLOTS) begin
            pvld_r <= 1'b1;
            pidx_r <= IW'(sa_r);
            sa_r   <= sa_r + CW'(1);
            rb_r   <= (rb_r == BK_MAX) ? '0 : rb_r + BW'(1);
          end else begin
            pvld_r <= 1'b0;
          end
          // evaluate side
          if (pvld_r) begin
            if (hit_m && !hf_r) begin
              hf_r   <= 1'b1;
              hidx_r <= pidx_r;
              hrow_r <= tag_eff;
              hcnt_r <= cnt_eff;
            end
            if (vic_m) begin
              vf_r     <= 1'b1;
              vidx_r   <= pidx_r;
              vstamp_r <= tag_eff.stamp;
            end
            if (oth_m) begin
              of_r  <= 1'b1;
              obk_r <= tag_eff.bucket;
            end
            if (sa_r == SLOTS) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          priority if (hf_r) begin
            state_r              <= S_IDLE;
            use_clk_r            <= use_clk_r + 32'd1;
            out_valid_r          <= 1'b1;
            out_res_r.slot_out   <= 5'(hidx_r);
            out_res_r.status     <= hrow_r.valid ? blbct_pkg::ST_HIT : blbct_pkg::ST_FILL;
            out_res_r.was_stolen <= 1'b0;
          end else if (vf_r) begin
            state_r              <= S_IDLE;
            use_clk_r            <= use_clk_r + 32'd1;
            out_valid_r          <= 1'b1;
            out_res_r.slot_out   <= 5'(vidx_r);
            out_res_r.status     <= blbct_pkg::ST_FILL;
            out_res_r.was_stolen <= pass2_r;
          end else if (!pass2_r && of_r) begin
            // second pass over the lowest numbered other bucket that has a free slot
            state_r <= S_SCAN;
            pass2_r <= 1'b1;
            sa_r    <= '0;
            rb_r    <= '0;
            pvld_r  <= 1'b0;
          end else begin
            state_r              <= S_IDLE;
            out_valid_r          <= 1'b1;
            out_res_r.slot_out   <= '0;
            out_res_r.status     <= blbct_pkg::ST_NOBUF;
            out_res_r.was_stolen <= 1'b0;
          end
        end
        S_CNT_RD: begin
          state_r <= S_CNT_UPD;
        end
        S_CNT_UPD: begin
          state_r              <= S_IDLE;
          out_valid_r          <= 1'b1;
          out_res_r.slot_out   <= job_r.req.slot_index;
          out_res_r.was_stolen <= 1'b0;
          if (job_r.req.func != blbct_pkg::FUNC_PIN && cnt_eff == '0) begin
            out_res_r.status <= blbct_pkg::ST_UNDERFLOW;
          end else begin
            out_res_r.status <= blbct_pkg::ST_UPDATED;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ rtl/bucketed_lru_buffer_cache_tags_core.sv @@
// top level of the bucketed lru buffer cache tag controller
//
// Usage: drive a request on in_req and raise start; it is taken at a clock
// edge where start is high and busy is low. func selects read, release,
// pin or unpin. Every request gives exactly one result on out_res, shown
// for a single cycle with out_valid high; the receiver cannot stall it and
// must take it in that cycle.
// A read is held in the front while its sector is folded, its quotient by
// the bucket count is taken by a reciprocal multiply and the remainder gives
// its home bucket; the back then makes one pass over all slots at one slot
// per cycle and strobes the result. A read that steals from another bucket
// makes a second pass. Release, pin and unpin skip the hash; the back reads
// the addressed count, then updates it and strobes the result. A two entry
// queue parts front and back, so the front hashes the next read while the
// back scans. The front holds one request at a time and stays busy until it
// is pushed, which waits while the queue is full; sustained reads are thus
// limited by the back's slot scan. Reset: rst_n low clears the front's
// holding register, the queue, sequencer, use clock and written marks;
// every slot then reads as its reset tag, count and home bucket at once.
module bucketed_lru_buffer_cache_tags_core #(
  parameter int SLOT_COUNT   = blbct_pkg::SLOT_COUNT_DEF,
  parameter int BUCKET_COUNT = blbct_pkg::BUCKET_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  blbct_pkg::in_t  in_req,
  output logic            busy,
  output logic            out_valid,
  output blbct_pkg::out_t out_res
);

  blbct_pkg::q_stat_t q_stat;
  blbct_pkg::job_t    push_job;
  blbct_pkg::job_t    head_job;
  logic               push;
  logic               pop;

  // request intake and bucket hash
  blbct_front #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // decoupling queue
  blbct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // tag and count engine
  blbct_back #(
    .SLOT_COUNT   (SLOT_COUNT),
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
